/* sv/spd_pkg.sv */
// Package for the serial packet deframer: field widths, phase, kind and
// register codes, and the default payload depth. No dependencies.
package spd_pkg;

  localparam int BYTE_W        = 8;
  localparam int KIND_W        = 2;
  localparam int INDEX_W       = 6;
  localparam int CFG_IDX_W     = 2;
  localparam int PHASE_W       = 3;
  localparam int PAYLOAD_MAX_D = 32;

  localparam logic [BYTE_W-1:0] TARGET_SELF = 8'd1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HDR    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CSUM   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OVFL   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_A     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_B     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_ID  = 2'd3;

  localparam logic [BYTE_W-1:0] BCAST_RESET = 8'd254;

  // Frame phases
  localparam logic [PHASE_W-1:0] PH_DEST = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SRC  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TGT  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PID  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LEN  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PAY  = 3'd5;
  localparam logic [PHASE_W-1:0] PH_CSUM = 3'd6;

endpackage

/* sv/serial_packet_deframer.sv */
// Serial packet deframer top level: header checks, payload store in a
// synchronous memory, checksum test and payload readout. Uses spd_pkg.
//
// channel | direction | handshake             | payload
// in_     | in        | in_valid / in_stall   | in_rx_byte
// out_    | out       | out_valid / out_stall | kind, packet_id, declared_len,
//         |           |                       | byte_index, byte_value, last
// cfg_    | in        | cfg_we                | cfg_idx, cfg_wdata
//
// A received byte is taken whenever no readout is running and the output
// register is free or being emptied. A good frame is read back from the
// payload store result by result, each through a memory read state and
// then a state that loads the output register, and the input is held off
// after its checksum until the last payload result has been loaded.
// Reset is synchronous and active low; the payload store needs no clearing.
// A stall on the output holds the result register and, through it, the input.
module serial_packet_deframer #(
  parameter int PAYLOAD_MAX = spd_pkg::PAYLOAD_MAX_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [spd_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [spd_pkg::KIND_W-1:0]     out_kind,
  output logic [spd_pkg::BYTE_W-1:0]     out_packet_id,
  output logic [spd_pkg::BYTE_W-1:0]     out_declared_len,
  output logic [spd_pkg::INDEX_W-1:0]    out_byte_index,
  output logic [spd_pkg::BYTE_W-1:0]     out_byte_value,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [spd_pkg::BYTE_W-1:0]     cfg_wdata
);
  import spd_pkg::*;

  localparam int AW = $clog2(PAYLOAD_MAX);
  localparam int CW = $clog2(PAYLOAD_MAX + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(PAYLOAD_MAX);

  // Readout sequencer
  localparam logic [1:0] RD_IDLE = 2'd0;
  localparam logic [1:0] RD_READ = 2'd1;
  localparam logic [1:0] RD_EMIT = 2'd2;

  logic [BYTE_W-1:0]  own_id_r, src_a_r, src_b_r, bcast_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [BYTE_W-1:0]  sum_r, sum_nxt;
  logic [BYTE_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0]  pid_r, pid_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [1:0]         rd_st_r, rd_st_nxt;
  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;

  logic [BYTE_W-1:0]  store_mem [PAYLOAD_MAX];
  logic [BYTE_W-1:0]  rd_data_r;
  logic               mem_we;

  logic               out_valid_r;
  logic [KIND_W-1:0]  kind_r;
  logic [BYTE_W-1:0]  opid_r, olen_r, oval_r;
  logic [INDEX_W-1:0] oidx_r;
  logic               olast_r;

  logic               out_free, in_acc, ld;
  logic [KIND_W-1:0]  ld_kind;
  logic [BYTE_W-1:0]  ld_pid, ld_len, ld_val;
  logic [INDEX_W-1:0] ld_idx;
  logic               emit_last;
  logic [BYTE_W-1:0]  sum_add;
  logic [CW-1:0]      cnt_inc;

  assign out_free = !out_valid_r || !out_stall;
  // Input and readout never overlap, so store writes and reads cannot collide
  assign in_stall = (rd_st_r != RD_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign sum_add  = sum_r + in_rx_byte;
  assign cnt_inc  = cnt_r + CW'(1);
  assign emit_last = (CW'(rd_idx_r) + CW'(1)) == cnt_r;
  assign mem_we   = in_acc && (phase_r == PH_PAY);

  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    len_nxt    = len_r;
    pid_nxt    = pid_r;
    cnt_nxt    = cnt_r;
    rd_st_nxt  = rd_st_r;
    rd_idx_nxt = rd_idx_r;
    ld         = 1'b0;
    ld_kind    = KIND_HDR;
    ld_pid     = '0;
    ld_len     = '0;
    ld_idx     = '0;
    ld_val     = '0;
    if (in_acc) begin
      case (phase_r)
        PH_SRC: begin
          if (in_rx_byte == src_a_r || in_rx_byte == src_b_r) begin
            sum_nxt   = sum_add;
            phase_nxt = PH_TGT;
          end else begin
            ld        = 1'b1;
            phase_nxt = PH_DEST;
          end
        end
        PH_TGT: begin
          if (in_rx_byte == TARGET_SELF || in_rx_byte == bcast_r) begin
            sum_nxt   = sum_add;
            phase_nxt = PH_PID;
          end else begin
            ld        = 1'b1;
            phase_nxt = PH_DEST;
          end
        end
        PH_PID: begin
          sum_nxt   = sum_add;
          pid_nxt   = in_rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          sum_nxt   = sum_add;
          len_nxt   = in_rx_byte;
          cnt_nxt   = '0;
          phase_nxt = PH_PAY;
        end
        PH_PAY: begin
          sum_nxt = sum_add;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= CNT_MAX) begin
            ld        = 1'b1;
            ld_kind   = KIND_OVFL;
            ld_pid    = pid_r;
            ld_len    = len_r;
            cnt_nxt   = '0;
            phase_nxt = PH_DEST;
          end else if (BYTE_W'(cnt_inc) >= len_r) begin
            phase_nxt = PH_CSUM;
          end
        end
        PH_CSUM: begin
          sum_nxt   = sum_add;
          phase_nxt = PH_DEST;
          if (sum_add == '0) begin
            rd_idx_nxt = '0;
            rd_st_nxt  = RD_READ;
          end else begin
            ld      = 1'b1;
            ld_kind = KIND_CSUM;
            ld_pid  = pid_r;
            ld_len  = len_r;
          end
        end
        default: begin
          // Destination byte; unused phase codes land here as well
          if (in_rx_byte == own_id_r) begin
            sum_nxt   = in_rx_byte;
            phase_nxt = PH_SRC;
          end else begin
            ld        = 1'b1;
            phase_nxt = PH_DEST;
          end
        end
      endcase
    end else begin
      case (rd_st_r)
        RD_READ: rd_st_nxt = RD_EMIT;
        RD_EMIT: begin
          if (out_free) begin
            ld      = 1'b1;
            ld_kind = KIND_DATA;
            ld_pid  = pid_r;
            ld_len  = len_r;
            ld_idx  = INDEX_W'(rd_idx_r);
            ld_val  = rd_data_r;
            if (emit_last) begin
              rd_st_nxt = RD_IDLE;
            end else begin
              rd_idx_nxt = rd_idx_r + AW'(1);
              rd_st_nxt  = RD_READ;
            end
          end
        end
        default: rd_st_nxt = RD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= '0;
      src_a_r  <= '0;
      src_b_r  <= '0;
      bcast_r  <= BCAST_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OWN_ID:   own_id_r <= cfg_wdata;
        REG_SRC_A:    src_a_r  <= cfg_wdata;
        REG_SRC_B:    src_b_r  <= cfg_wdata;
        REG_BCAST_ID: bcast_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_DEST;
      sum_r    <= '0;
      len_r    <= '0;
      pid_r    <= '0;
      cnt_r    <= '0;
      rd_st_r  <= RD_IDLE;
      rd_idx_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      sum_r    <= sum_nxt;
      len_r    <= len_nxt;
      pid_r    <= pid_nxt;
      cnt_r    <= cnt_nxt;
      rd_st_r  <= rd_st_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[cnt_r[AW-1:0]] <= in_rx_byte;
    end
    rd_data_r <= store_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      kind_r  <= ld_kind;
      opid_r  <= ld_pid;
      olen_r  <= ld_len;
      oidx_r  <= ld_idx;
      oval_r  <= ld_val;
      olast_r <= (ld_kind != KIND_DATA) || emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_packet_id    = opid_r;
  assign out_declared_len = olen_r;
  assign out_byte_index   = oidx_r;
  assign out_byte_value   = oval_r;
  assign out_last         = olast_r;

  // A result is never loaded over one that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !ld)
    else $error("result register overwritten while stalled");

  // Store writes stay inside the payload store
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (cnt_r < CNT_MAX))
    else $error("payload store write beyond depth");

  // Checksum phase always follows at least one payload byte
  a_csum_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CSUM) |-> (cnt_r != '0))
    else $error("checksum phase with empty payload");

  // Readout index never passes the payload count
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_st_r != RD_IDLE) |-> (CW'(rd_idx_r) < cnt_r))
    else $error("readout index beyond payload count");

  // The final payload result ends the readout
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_st_r == RD_EMIT && out_free && emit_last) |=> (rd_st_r == RD_IDLE))
    else $error("readout continued past the last payload byte");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for serial_packet_deframer: frames in, payload runs and error results out.
// Depends on spd_pkg and the deframer RTL only.
module tb_top;
  import spd_pkg::*;

  localparam int PAYLOAD_MAX        = PAYLOAD_MAX_D;
  localparam int RANDOM_PER_SETTING = 26;
  localparam int DRAIN_CYCLES       = 2 * PAYLOAD_MAX + 16;
  localparam int SETTLE_LIMIT       = 20000;
  localparam int NO_FAULT           = -1;
  localparam int TIMEOUT_NS         = 2000000;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  pid;
    logic [BYTE_W-1:0]  dlen;
    logic [INDEX_W-1:0] idx;
    logic [BYTE_W-1:0]  val;
    logic               last;
  } deframe_result_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_pattern_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_W-1:0]    out_kind;
  logic [BYTE_W-1:0]    out_packet_id;
  logic [BYTE_W-1:0]    out_declared_len;
  logic [INDEX_W-1:0]   out_byte_index;
  logic [BYTE_W-1:0]    out_byte_value;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [BYTE_W-1:0]    cfg_wdata = '0;

  // Registers as the deframer should hold them
  logic [BYTE_W-1:0] cur_own = 8'd0;
  logic [BYTE_W-1:0] cur_src_a = 8'd0;
  logic [BYTE_W-1:0] cur_src_b = 8'd0;
  logic [BYTE_W-1:0] cur_bcast = BCAST_RESET;

  // Frame state as the deframer should hold it
  logic [PHASE_W-1:0] rx_state = PH_DEST;
  logic [BYTE_W-1:0]  csum_acc = '0;
  logic [BYTE_W-1:0]  len_rx = '0;
  logic [BYTE_W-1:0]  pid_rx = '0;
  int                 pay_count = 0;
  logic [BYTE_W-1:0]  pay_buf [PAYLOAD_MAX];

  deframe_result_t frame_results [$];

  int fail_count = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int settings_used = 1;
  int burst_left = 1;
  int kind_seen [4] = '{default: 0};

  stall_pattern_t stall_mode = STALL_NONE;
  int             stall_tick = 0;

  serial_packet_deframer #(.PAYLOAD_MAX(PAYLOAD_MAX)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_packet_id(out_packet_id), .out_declared_len(out_declared_len),
    .out_byte_index(out_byte_index), .out_byte_value(out_byte_value),
    .out_last(out_last),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void add_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] pid,
                                     logic [BYTE_W-1:0] dlen, logic [INDEX_W-1:0] idx,
                                     logic [BYTE_W-1:0] val, logic last);
    deframe_result_t r;
    r.kind = kind;
    r.pid  = pid;
    r.dlen = dlen;
    r.idx  = idx;
    r.val  = val;
    r.last = last;
    frame_results.push_back(r);
  endfunction

  // Advance the frame state by one received byte and queue what it produces
  function automatic void deframe_byte(logic [BYTE_W-1:0] b);
    int i;
    case (rx_state)
      PH_SRC: begin
        if (b == cur_src_a || b == cur_src_b) begin
          csum_acc = csum_acc + b;
          rx_state = PH_TGT;
        end else begin
          add_result(KIND_HDR, '0, '0, '0, '0, 1'b1);
          rx_state = PH_DEST;
        end
      end
      PH_TGT: begin
        if (b == TARGET_SELF || b == cur_bcast) begin
          csum_acc = csum_acc + b;
          rx_state = PH_PID;
        end else begin
          add_result(KIND_HDR, '0, '0, '0, '0, 1'b1);
          rx_state = PH_DEST;
        end
      end
      PH_PID: begin
        csum_acc = csum_acc + b;
        pid_rx = b;
        rx_state = PH_LEN;
      end
      PH_LEN: begin
        csum_acc = csum_acc + b;
        len_rx = b;
        pay_count = 0;
        rx_state = PH_PAY;
      end
      PH_PAY: begin
        csum_acc = csum_acc + b;
        if (pay_count < PAYLOAD_MAX) pay_buf[pay_count] = b;
        pay_count++;
        if (pay_count >= PAYLOAD_MAX) begin
          add_result(KIND_OVFL, pid_rx, len_rx, '0, '0, 1'b1);
          pay_count = 0;
          rx_state = PH_DEST;
        end else if (pay_count >= int'(len_rx)) begin
          rx_state = PH_CSUM;
        end
      end
      PH_CSUM: begin
        csum_acc = csum_acc + b;
        if (csum_acc == '0) begin
          for (i = 0; i < pay_count && i < PAYLOAD_MAX; i++)
            add_result(KIND_DATA, pid_rx, len_rx, i[INDEX_W-1:0], pay_buf[i],
                       i + 1 == pay_count);
        end else begin
          add_result(KIND_CSUM, pid_rx, len_rx, '0, '0, 1'b1);
        end
        rx_state = PH_DEST;
      end
      default: begin
        if (b == cur_own) begin
          csum_acc = b;
          rx_state = PH_SRC;
        end else begin
          add_result(KIND_HDR, '0, '0, '0, '0, 1'b1);
          rx_state = PH_DEST;
        end
      end
    endcase
  endfunction

  function automatic bit hdr_ok(logic [PHASE_W-1:0] ph, logic [BYTE_W-1:0] v);
    case (ph)
      PH_DEST: return v == cur_own;
      PH_SRC:  return v == cur_src_a || v == cur_src_b;
      default: return v == TARGET_SELF || v == cur_bcast;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_target();
    return $urandom_range(0, 1) ? TARGET_SELF : cur_bcast;
  endfunction

  function automatic void check_field(string name, logic [BYTE_W-1:0] want,
                                      logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    deframe_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (frame_results.size() == 0) begin
        $error("result with nothing pending: kind %0d index %0d", out_kind, out_byte_index);
        fail_count++;
      end else begin
        want = frame_results.pop_front();
        check_field("kind", BYTE_W'(want.kind), BYTE_W'(out_kind));
        check_field("packet_id", want.pid, out_packet_id);
        check_field("declared_len", want.dlen, out_declared_len);
        check_field("byte_index", BYTE_W'(want.idx), BYTE_W'(out_byte_index));
        check_field("byte_value", want.val, out_byte_value);
        check_field("last", BYTE_W'(want.last), BYTE_W'(out_last));
        kind_seen[want.kind]++;
        results_checked++;
      end
    end
  end

  // Receiver back-pressure: switch stall pattern when a random countdown runs out
  always @(posedge clk) begin
    if (stall_tick == 0) begin
      stall_mode = stall_pattern_t'($urandom_range(0, 3));
      stall_tick = $urandom_range(16, 80);
    end
    stall_tick--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ~out_stall;
    endcase
  end

  // Hold the byte until taken, then idle now and then between bursts
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    deframe_byte(b);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] tgt, input logic [BYTE_W-1:0] pid,
                            input int len, input bit bad_sum, input int fault_at);
    logic [BYTE_W-1:0] fb [$];
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] v;
    int n;
    fb.push_back(cur_own);
    fb.push_back($urandom_range(0, 1) ? cur_src_a : cur_src_b);
    fb.push_back(tgt);
    fb.push_back(pid);
    fb.push_back(len[BYTE_W-1:0]);
    n = (len >= PAYLOAD_MAX) ? PAYLOAD_MAX : ((len == 0) ? 1 : len);
    repeat (n) begin
      v = BYTE_W'($urandom);
      fb.push_back(v);
    end
    // an overflowing frame is cut off before its checksum
    if (len < PAYLOAD_MAX) begin
      acc = '0;
      foreach (fb[i]) acc = acc + fb[i];
      acc = -acc;
      if (bad_sum) acc = acc + BYTE_W'($urandom_range(1, 255));
      fb.push_back(acc);
    end
    if (fault_at != NO_FAULT) begin
      do v = BYTE_W'($urandom); while (hdr_ok(fault_at[PHASE_W-1:0], v));
      fb[fault_at] = v;
      while (fb.size() > fault_at + 1) void'(fb.pop_back());
    end
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_OWN_ID: cur_own   = val;
      REG_SRC_A:  cur_src_a = val;
      REG_SRC_B:  cur_src_b = val;
      default:    cur_bcast = val;
    endcase
  endtask

  task automatic set_config(input logic [BYTE_W-1:0] own, input logic [BYTE_W-1:0] src_a,
                            input logic [BYTE_W-1:0] src_b, input logic [BYTE_W-1:0] bcast);
    write_reg(REG_OWN_ID, own);
    write_reg(REG_SRC_A, src_a);
    write_reg(REG_SRC_B, src_b);
    write_reg(REG_BCAST_ID, bcast);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Drop valid, wait for every pending result, then let the readout run dry
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (frame_results.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (frame_results.size() != 0) begin
      $error("%0d results never arrived", frame_results.size());
      fail_count++;
      frame_results.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Reset registers: own 0, sources 0, broadcast 254
  task automatic test_header_errors();
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(8'h07);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_zero_length();
    send_frame(TARGET_SELF, 8'h00, 0, 1'b0, NO_FAULT);
  endtask

  task automatic test_checksum_error();
    send_frame(cur_bcast, 8'hFF, 1, 1'b1, NO_FAULT);
  endtask

  task automatic test_long_frames();
    send_frame(TARGET_SELF, 8'h3C, PAYLOAD_MAX - 1, 1'b0, NO_FAULT);
    send_frame(cur_bcast, 8'hC3, 255, 1'b0, NO_FAULT);
  endtask

  task automatic test_random_traffic(input int budget);
    int stop_at;
    int pick;
    int len;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
      end else if (pick < 18) begin
        send_frame(pick_target(), BYTE_W'($urandom), $urandom_range(0, 8), 1'b0,
                   $urandom_range(int'(PH_DEST), int'(PH_TGT)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10)      len = 0;
        else if (pick < 75) len = $urandom_range(1, 8);
        else if (pick < 94) len = $urandom_range(9, PAYLOAD_MAX - 1);
        else                len = $urandom_range(PAYLOAD_MAX, 255);
        send_frame(pick_target(), BYTE_W'($urandom), len, $urandom_range(0, 6) == 0,
                   NO_FAULT);
      end
    end
    // leave a frame open so the next register change lands mid-frame
    if ($urandom_range(0, 1)) begin
      send_byte(cur_own);
      send_byte(cur_src_b);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_header_errors();
    test_zero_length();
    test_checksum_error();
    test_long_frames();

    settle();
    set_config(8'hFF, 8'hFF, 8'h00, 8'hFF);
    test_random_traffic(RANDOM_PER_SETTING);
    settle();
    set_config(8'h00, 8'h80, 8'hFF, 8'h00);
    test_random_traffic(RANDOM_PER_SETTING);
    settle();
    set_config(8'h5A, 8'hA5, 8'hA5, TARGET_SELF);
    test_random_traffic(RANDOM_PER_SETTING);
    repeat (2) begin
      settle();
      set_config(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                 BYTE_W'($urandom));
      test_random_traffic(RANDOM_PER_SETTING);
    end
    settle();

    $display("Deframer run: %0d bytes under %0d register settings, %0d results checked",
             bytes_sent, settings_used, results_checked);
    $display("  by kind: %0d payload, %0d header error, %0d checksum error, %0d overflow",
             kind_seen[KIND_DATA], kind_seen[KIND_HDR], kind_seen[KIND_CSUM],
             kind_seen[KIND_OVFL]);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
